>>> rtl/core/swm_pkg.sv
package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_W        = 7;
    localparam int IDX_W        = $clog2(MAX_WINDOW);
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int GROUP        = 8;
    localparam int NGROUP       = MAX_WINDOW / GROUP;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [CNT_W-1:0]               count_t;
    typedef logic [IDX_W-1:0]               index_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic    shift_en;
        logic    restart;
        sample_t sample;
        count_t  window;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_FINAL,
        ST_OUT
    } swm_state_t;

endpackage

>>> rtl/core/swm_if.sv
interface swm_in_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t window_max;

    modport source (output valid, output window_max, input ready);
    modport sink (input valid, input window_max, output ready);
endinterface

>>> rtl/core/swm_cell.sv
module swm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  swm_pkg::cell_ctl_t ctl,
    input  logic               head,
    input  swm_pkg::index_t    cell_idx,
    input  logic               prev_valid,
    input  swm_pkg::sample_t   prev_value,
    output logic               valid,
    output swm_pkg::sample_t   value
);
    import swm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t value_reg;

    // an entry survives the shift unless a newer, larger sample hides it,
    // it has aged out of the window, or the sequence restarts
    always_comb
    begin
        if (head)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = prev_valid && !ctl.restart && (prev_value >= ctl.sample)
                         && (32'(cell_idx) < 32'(ctl.window));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift_en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            value_reg <= prev_value;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

>>> rtl/core/swm_front_sel.sv
module swm_front_sel (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cap_en,
    input  logic             cell_valid [swm_pkg::MAX_WINDOW],
    input  swm_pkg::sample_t cell_value [swm_pkg::MAX_WINDOW],
    output logic             front_found,
    output swm_pkg::sample_t front_value
);
    import swm_pkg::*;

    logic    grp_valid_reg [NGROUP];
    sample_t grp_value_reg [NGROUP];
    logic    grp_valid_next [NGROUP];
    sample_t grp_value_next [NGROUP];

    // oldest live entry in each group of cells (highest index wins)
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_valid_next[g] = 1'b0;
            grp_value_next[g] = cell_value[g*GROUP];
            for (int j = 0; j < GROUP; j++)
            begin
                if (cell_valid[g*GROUP + j])
                begin
                    grp_valid_next[g] = 1'b1;
                    grp_value_next[g] = cell_value[g*GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                grp_valid_reg[g] <= 1'b0;
            end
        end
        else if (cap_en)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                grp_valid_reg[g] <= grp_valid_next[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                grp_value_reg[g] <= grp_value_next[g];
            end
        end
    end

    always_comb
    begin
        front_found = 1'b0;
        front_value = grp_value_reg[0];
        for (int g = 0; g < NGROUP; g++)
        begin
            if (grp_valid_reg[g])
            begin
                front_found = 1'b1;
                front_value = grp_value_reg[g];
            end
        end
    end

endmodule

>>> rtl/core/sliding_window_maximum.sv
// Running maximum of the last window_size signed samples. A chain of 64 cells
// holds the last samples, newest in cell 0, shifting one place per accepted
// item; a cell drops its entry once a newer larger sample arrives or it falls
// out of the window, so the oldest live cell always holds the maximum. An item
// taken in IDLE goes through GROUP and FINAL, the two-level registered search
// for the oldest live cell, and then through OUT, where it waits for the sink,
// if it yields a result; only back in IDLE is a new item taken. restart clears
// the chain and the fill count before its sample is taken. window_size 0 acts
// as 1 and values above 64 act as 64; write it only while the block is idle. No
// result is given until the window has filled since reset or the last restart.
module sliding_window_maximum (
    input  logic                      clk,
    input  logic                      rst_n,
    swm_in_if.sink                    in_ch,
    swm_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] cfg_wdata
);
    import swm_pkg::*;

    swm_state_t       state_reg;
    swm_state_t       state_next;
    logic [CFG_W-1:0] window_reg;
    count_t           window_eff;
    count_t           filled_reg;
    count_t           filled_next;
    count_t           filled_base;
    logic             res_reg;
    logic             res_next;
    sample_t          out_value_reg;
    logic             accept;
    logic             cap_en;
    logic             load_out;
    cell_ctl_t        ctl;
    logic             cell_valid [MAX_WINDOW];
    sample_t          cell_value [MAX_WINDOW];
    logic             front_found;
    sample_t          front_value;

    always_comb
    begin
        if (window_reg == '0)
        begin
            window_eff = count_t'(1);
        end
        else if (32'(window_reg) > 32'(MAX_WINDOW))
        begin
            window_eff = count_t'(MAX_WINDOW);
        end
        else
        begin
            window_eff = count_t'(window_reg);
        end
    end

    assign accept = in_ch.valid && in_ch.ready;

    assign ctl.shift_en = accept;
    assign ctl.restart  = in_ch.restart;
    assign ctl.sample   = in_ch.sample;
    assign ctl.window   = window_eff;

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                swm_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .head       (1'b1),
                    .cell_idx   (index_t'(i)),
                    .prev_valid (1'b1),
                    .prev_value (in_ch.sample),
                    .valid      (cell_valid[i]),
                    .value      (cell_value[i])
                );
            end
            else
            begin : g_body
                swm_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .head       (1'b0),
                    .cell_idx   (index_t'(i)),
                    .prev_valid (cell_valid[i-1]),
                    .prev_value (cell_value[i-1]),
                    .valid      (cell_valid[i]),
                    .value      (cell_value[i])
                );
            end
        end
    endgenerate

    swm_front_sel u_front_sel (
        .clk         (clk),
        .rst_n       (rst_n),
        .cap_en      (cap_en),
        .cell_valid  (cell_valid),
        .cell_value  (cell_value),
        .front_found (front_found),
        .front_value (front_value)
    );

    // fill count saturates at the window in force
    always_comb
    begin
        filled_base = in_ch.restart ? '0 : filled_reg;
        if (filled_base < window_eff)
        begin
            filled_next = filled_base + count_t'(1);
        end
        else
        begin
            filled_next = filled_base;
        end
        res_next = (filled_next >= window_eff);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_GROUP;
                end
            end
            ST_GROUP:
            begin
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                state_next = res_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ch.ready  = (state_reg == ST_IDLE);
        cap_en       = (state_reg == ST_GROUP);
        load_out     = (state_reg == ST_FINAL) && res_reg;
        out_ch.valid = (state_reg == ST_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            window_reg <= CFG_W'(1);
            filled_reg <= '0;
            res_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (accept)
            begin
                filled_reg <= filled_next;
                res_reg    <= res_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= front_value;
        end
    end

    assign out_ch.window_max = out_value_reg;

    a_front_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINAL |-> front_found)
        else $error("no live cell found after an item");

    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cell_valid[0])
        else $error("newest cell not live after an item");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= count_t'(MAX_WINDOW))
        else $error("fill count beyond chain length");

    a_out_has_res: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> res_reg)
        else $error("result shown for an item that yields none");

endmodule

>>> bench/tb_top.sv
module tb_top;
    import swm_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_PHASES     = 11;
    localparam int MAX_ROWS     = 32;
    localparam int DUE_DEPTH    = 16;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_W-1:0] cfg_val;
        logic             restart;
        sample_t          sample;
        logic             typed;
        sample_t          max_val;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    swm_in_if  in_ch();
    swm_out_if out_ch();

    sliding_window_maximum u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // own copy of the block state
    sample_t          cand_val [0:MAX_WINDOW-1];
    logic [IDX_W:0]   cand_pos [0:MAX_WINDOW-1];
    int               cand_n;
    logic [IDX_W:0]   next_pos;
    int               fill_count;
    logic [CFG_W-1:0] window_reg;

    // expected results, oldest at due_rd
    sample_t  due_val [0:DUE_DEPTH-1];
    int       due_wr;
    int       due_rd;
    int       mismatch_count;
    int       cycle_count;
    bit       src_gaps;
    bit       snk_gaps;
    bit       hold_req;
    dir_row_t plan [0:MAX_ROWS-1];
    int       n_rows;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void drop_oldest();
        for (int k = 0; k + 1 < cand_n; k++)
        begin
            cand_val[k] = cand_val[k+1];
            cand_pos[k] = cand_pos[k+1];
        end
        cand_n--;
    endfunction

    function automatic bit predict_window_max(input sample_t s, input logic rst,
                                              output sample_t m);
        int             w;
        logic [IDX_W:0] age;
        bit             done;
        w = (window_reg == 0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg);
        if (rst)
        begin
            cand_n = 0;
            fill_count = 0;
            next_pos = '0;
        end
        // more than one front entry can expire after the window shrinks
        done = 1'b0;
        while (!done && cand_n > 0)
        begin
            age = next_pos - cand_pos[0];
            if (age >= w)
                drop_oldest();
            else
                done = 1'b1;
        end
        // equal values stay, the new one goes behind them
        while (cand_n > 0 && cand_val[cand_n-1] < s)
            cand_n--;
        if (cand_n >= MAX_WINDOW)
            drop_oldest();
        cand_val[cand_n] = s;
        cand_pos[cand_n] = next_pos;
        cand_n++;
        next_pos = next_pos + 1'b1;
        if (fill_count < w)
            fill_count++;
        m = cand_val[0];
        return fill_count >= w;
    endfunction

    task automatic send_item(input sample_t s, input logic rst, input logic typed,
                             input sample_t typed_max);
        int      gap;
        sample_t m;
        @(negedge clk);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.restart <= rst;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        if (predict_window_max(s, rst, m))
        begin
            due_val[due_wr % DUE_DEPTH] = typed ? typed_max : m;
            due_wr++;
        end
    endtask

    // only touched while the block is idle
    task automatic apply_window(input logic [CFG_W-1:0] v);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (due_wr != due_rd)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        window_reg = v;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [CFG_W-1:0] cfg_val,
                           input logic rst, input sample_t s, input logic typed,
                           input sample_t max_val);
        plan[n_rows].kind    = kind;
        plan[n_rows].cfg_val = cfg_val;
        plan[n_rows].restart = rst;
        plan[n_rows].sample  = s;
        plan[n_rows].typed   = typed;
        plan[n_rows].max_val = max_val;
        n_rows++;
    endtask

    function automatic sample_t next_sample(input sample_t prev);
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return sample_t'($urandom_range(0, 6)) - 16'sd3;
            4, 5:    return prev - sample_t'($urandom_range(0, 40));
            6:       return prev + sample_t'($urandom_range(0, 40));
            default: return sample_t'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (due_wr == due_rd)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: result %0d with none expected", out_ch.window_max);
            end
            else if (out_ch.window_max !== due_val[due_rd % DUE_DEPTH])
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: window_max expected %0d got %0d",
                             due_val[due_rd % DUE_DEPTH], out_ch.window_max);
                due_rd++;
            end
            else
                due_rd++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // output side: random stall bursts, plus one long hold-off
    initial
    begin
        int stall_len;
        int hold_count;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (snk_gaps && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_len = $urandom_range(1, 7);
                repeat (stall_len - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] phase_win [0:N_PHASES-1];
        int               i;
        int               p;
        int               eff;
        int               n_items;
        sample_t          s;
        logic             rst;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.sample   = '0;
        in_ch.restart  = 1'b0;
        src_gaps       = 1'b1;
        snk_gaps       = 1'b1;
        hold_req       = 1'b0;
        mismatch_count = 0;
        n_rows         = 0;
        cand_n         = 0;
        due_wr         = 0;
        due_rd         = 0;
        fill_count     = 0;
        next_pos       = '0;
        window_reg     = 7'd1;

        // window 1 after reset: every item gives itself back
        add_row(ROW_ITEM, 7'd0, 1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sh8000, 1'b1, 16'sh8000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'shFFFF, 1'b1, 16'shFFFF);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sh0000, 1'b1, 16'sh0000);
        // zero window acts as one
        add_row(ROW_CFG,  7'd0, 1'b0, 16'sh0000, 1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sh5555, 1'b1, 16'sh5555);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'shAAAA, 1'b1, 16'shAAAA);
        // equal values, then short sequences cut by restart
        add_row(ROW_CFG,  7'd3, 1'b0, 16'sh0000, 1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b1, 16'sd5,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd5,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd5,    1'b1, 16'sd5);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sh8000, 1'b1, 16'sd5);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sh7FFF, 1'b1, 16'sh7FFF);
        add_row(ROW_ITEM, 7'd0, 1'b1, 16'sd1,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b1, 16'sd2,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd3,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd4,    1'b1, 16'sd4);
        // falling run, then shrink the window so several front entries expire at once
        add_row(ROW_CFG,  7'd5, 1'b0, 16'sh0000, 1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b1, 16'sd9,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd8,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd7,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd6,    1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd5,    1'b1, 16'sd9);
        add_row(ROW_CFG,  7'd2, 1'b0, 16'sh0000, 1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sd1,    1'b1, 16'sd5);
        // oversize window saturates
        add_row(ROW_CFG,  7'd127, 1'b0, 16'sh0000, 1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b1, 16'sh8000, 1'b0, 16'sh0000);
        add_row(ROW_ITEM, 7'd0, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000);

        phase_win = '{7'd64, 7'd4, 7'd1, 7'd17, 7'd0, 7'd127, 7'd65, 7'd8, 7'd1, 7'd2, 7'd33};
        phase_win[8] = 7'($urandom_range(1, 64));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < n_rows; i++)
        begin
            if (plan[i].kind == ROW_CFG)
                apply_window(plan[i].cfg_val);
            else
                send_item(plan[i].sample, plan[i].restart, plan[i].typed, plan[i].max_val);
        end

        s = '0;
        for (p = 0; p < N_PHASES; p++)
        begin
            apply_window(phase_win[p]);
            eff = (phase_win[p] == 0) ? 1
                : ((phase_win[p] > MAX_WINDOW) ? MAX_WINDOW : phase_win[p]);
            n_items = (eff >= 33) ? 70 : 20;
            if (p >= N_PHASES - 2)
            begin
                src_gaps = 1'b0;
                snk_gaps = 1'b0;
            end
            else
            begin
                src_gaps = ($urandom_range(0, 3) != 0);
                snk_gaps = ($urandom_range(0, 3) != 0);
            end
            // every item of a window-1 phase yields a result, so the block backs up
            if (p == 2)
                hold_req = 1'b1;
            for (i = 0; i < n_items; i++)
            begin
                s = next_sample(s);
                rst = ($urandom_range(0, 2 * eff + 10) == 0);
                send_item(s, rst, 1'b0, '0);
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (due_wr != due_rd)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && due_wr == due_rd)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> sliding_window_maximum.f
rtl/core/swm_pkg.sv
rtl/core/swm_if.sv
rtl/core/swm_cell.sv
rtl/core/swm_front_sel.sv
rtl/core/sliding_window_maximum.sv
bench/tb_top.sv
